>>> design/bcomp_pkg.sv
// Package for the barometer compensation block.
// Holds the sequencer state type, register indexes and fixed constants.
`default_nettype none
package bcomp_pkg;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CALC = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    localparam logic [2:0] CFG_AC1_AC2 = 3'd0;
    localparam logic [2:0] CFG_AC3_AC4 = 3'd1;
    localparam logic [2:0] CFG_AC5_AC6 = 3'd2;
    localparam logic [2:0] CFG_B1_B2   = 3'd3;
    localparam logic [2:0] CFG_MC_MD   = 3'd4;
    localparam logic [2:0] CFG_OSS     = 3'd5;

    localparam logic REQ_TEMP = 1'b0;
    localparam logic REQ_PRES = 1'b1;

    localparam logic [31:0] C_4000  = 32'd4000;
    localparam logic [31:0] C_32768 = 32'd32768;
    localparam logic [31:0] C_50000 = 32'd50000;
    localparam logic [31:0] C_3038  = 32'd3038;
    localparam logic [31:0] C_M7357 = 32'hFFFF_E343;
    localparam logic [31:0] C_3791  = 32'd3791;
    localparam logic [31:0] C_HALF  = 32'h8000_0000;

endpackage
`default_nettype wire

>>> design/bcomp_in_if.sv
// Input channel of the barometer compensation block.
// Carries request type and raw reading; no dependencies.
`default_nettype none
interface bcomp_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [23:0] raw_reading;
    modport source (output valid, output req_type, output raw_reading, input ready);
    modport sink   (input valid, input req_type, input raw_reading, output ready);
endinterface
`default_nettype wire

>>> design/bcomp_out_if.sv
// Output channel of the barometer compensation block.
// Carries the result kind, value and divide error flag; no dependencies.
`default_nettype none
interface bcomp_out_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic signed [31:0] result_value;
    logic               div_error;
    modport source (output valid, output result_kind, output result_value,
                    output div_error, input ready);
    modport sink   (input valid, input result_kind, input result_value,
                    input div_error, output ready);
endinterface
`default_nettype wire

>>> design/barometer_compensation.sv
// Barometer compensation top level: config registers, step sequencer,
// bit-serial shift-add multiplier and restoring divider.
// Depends on bcomp_pkg, bcomp_in_if and bcomp_out_if.
//
// Usage:
//   i_in  : item = {req_type, raw_reading}; 0 temperature, 1 pressure.
//   o_out : item = {result_kind, result_value, div_error}.
//   Config: i_cfg_we/i_cfg_idx/i_cfg_data, write only while idle.
// Arithmetic: each multiply or divide is set up in S_CALC, then takes one
//   operand bit per cycle through the shared 64-bit accumulator or 32-bit remainder.
//   Temperature: 1 multiply, 1 divide per item.
//   Pressure: 10 multiplies, 1 divide per item.
//   One item at a time; i_in.ready is high only while the sequencer idles,
//   so the next item can be accepted in the cycle after the result is loaded.
// Output: a result register holds the finished item; a new item is taken
//   while it waits. If the receiver stalls, the next finished result waits
//   in the sequencer until the register frees.
// Reset: clears config registers, stored B5, sequencer and output valid.
`default_nettype none
module barometer_compensation
    import bcomp_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    bcomp_in_if.sink   i_in,
    bcomp_out_if.source o_out,
    input  wire        i_cfg_we,
    input  wire [2:0]  i_cfg_idx,
    input  wire [31:0] i_cfg_data
);

    t_state r_state, n_state;
    logic [3:0]  r_step, n_step;
    logic        r_kind, n_kind;
    logic [23:0] r_raw, n_raw;
    logic [31:0] r_b5, n_b5;
    logic [31:0] r_ac12, r_ac34, r_ac56, r_b12, r_mcmd;
    logic [1:0]  r_oss;
    logic [63:0] r_ma, n_ma, r_acc, n_acc;
    logic [31:0] r_mb, n_mb;
    logic [4:0]  r_cnt, n_cnt;
    logic [31:0] r_rem, n_rem, r_quo, n_quo, r_dvs, n_dvs;
    logic        r_neg, n_neg;
    logic [31:0] r_t1, n_t1, r_b6, n_b6, r_sq, n_sq, r_b3, n_b3;
    logic [31:0] r_b4, n_b4, r_b7, n_b7, r_p, n_p;
    logic [31:0] r_res, n_res;
    logic        r_err, n_err;
    logic        r_ov, n_ov;
    logic        r_okind, n_okind;
    logic [31:0] r_oval, n_oval;
    logic        r_oerr, n_oerr;

    logic        w_mul_go, w_div_go, w_fin;
    logic [63:0] w_mul_a;
    logic [31:0] w_mul_b, w_div_n, w_div_d;
    logic [31:0] w_p32, w_x1, w_den, w_num, w_q, w_x3, w_up, w_pa, w_tmp;
    logic [32:0] w_sh;
    logic [31:0] w_ac1, w_ac2, w_ac3, w_ac4, w_ac5, w_ac6, w_bb1, w_bb2, w_mc, w_md;

    assign w_ac1 = {{16{r_ac12[31]}}, r_ac12[31:16]};
    assign w_ac2 = {{16{r_ac12[15]}}, r_ac12[15:0]};
    assign w_ac3 = {{16{r_ac34[31]}}, r_ac34[31:16]};
    assign w_ac4 = {16'd0, r_ac34[15:0]};
    assign w_ac5 = {16'd0, r_ac56[31:16]};
    assign w_ac6 = {16'd0, r_ac56[15:0]};
    assign w_bb1 = {{16{r_b12[31]}}, r_b12[31:16]};
    assign w_bb2 = {{16{r_b12[15]}}, r_b12[15:0]};
    assign w_mc  = {{16{r_mcmd[31]}}, r_mcmd[31:16]};
    assign w_md  = {{16{r_mcmd[15]}}, r_mcmd[15:0]};

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ov;
    assign o_out.result_kind  = r_okind;
    assign o_out.result_value = r_oval;
    assign o_out.div_error    = r_oerr;

    always_comb begin
        n_state = r_state; n_step = r_step; n_kind = r_kind; n_raw = r_raw;
        n_b5 = r_b5; n_ma = r_ma; n_mb = r_mb; n_acc = r_acc; n_cnt = r_cnt;
        n_rem = r_rem; n_quo = r_quo; n_dvs = r_dvs; n_neg = r_neg;
        n_t1 = r_t1; n_b6 = r_b6; n_sq = r_sq; n_b3 = r_b3; n_b4 = r_b4;
        n_b7 = r_b7; n_p = r_p; n_res = r_res; n_err = r_err;
        n_ov = r_ov; n_okind = r_okind; n_oval = r_oval; n_oerr = r_oerr;
        w_mul_go = 1'b0; w_div_go = 1'b0; w_fin = 1'b0;
        w_mul_a = '0; w_mul_b = '0; w_div_n = '0; w_div_d = '0;
        w_p32 = r_acc[31:0];
        w_x1 = '0; w_den = '0; w_num = '0; w_q = '0; w_x3 = '0; w_pa = '0;
        w_tmp = '0;
        w_up = 32'(r_raw >> (4'd8 - {2'b00, r_oss}));
        w_sh = {r_rem, r_quo[31]};

        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_kind  = i_in.req_type;
                    n_raw   = i_in.raw_reading;
                    n_step  = 4'd0;
                    n_state = S_CALC;
                end
            end
            S_MUL: begin
                if (r_mb[0]) begin
                    n_acc = r_acc + r_ma;
                end
                n_ma  = {r_ma[62:0], 1'b0};
                n_mb  = {1'b0, r_mb[31:1]};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = S_CALC;
                end
            end
            S_DIV: begin
                if (w_sh >= {1'b0, r_dvs}) begin
                    n_rem = 32'(w_sh - {1'b0, r_dvs});
                    n_quo = {r_quo[30:0], 1'b1};
                end else begin
                    n_rem = w_sh[31:0];
                    n_quo = {r_quo[30:0], 1'b0};
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                if (r_kind == REQ_TEMP) begin
                    case (r_step)
                        4'd0: begin
                            w_tmp    = {16'd0, r_raw[15:0]} - w_ac6;
                            w_mul_a  = {{32{w_tmp[31]}}, w_tmp};
                            w_mul_b  = w_ac5;
                            w_mul_go = 1'b1;
                        end
                        4'd1: begin
                            w_x1  = r_acc[46:15];
                            w_den = w_x1 + w_md;
                            n_t1  = w_x1;
                            if (w_den == 32'd0) begin
                                n_res = '0; n_err = 1'b1; w_fin = 1'b1;
                            end else begin
                                w_num    = {w_mc[20:0], 11'd0};
                                w_div_n  = w_num[31] ? 32'(-w_num) : w_num;
                                w_div_d  = w_den[31] ? 32'(-w_den) : w_den;
                                n_neg    = w_num[31] ^ w_den[31];
                                w_div_go = 1'b1;
                            end
                        end
                        default: begin
                            w_q   = r_neg ? 32'(-r_quo) : r_quo;
                            w_tmp = r_t1 + w_q;
                            n_b5  = w_tmp;
                            n_res = 32'($signed(w_tmp + 32'd8) >>> 4);
                            n_err = 1'b0;
                            w_fin = 1'b1;
                        end
                    endcase
                end else begin
                    case (r_step)
                        4'd0: begin
                            w_tmp    = r_b5 - C_4000;
                            n_b6     = w_tmp;
                            w_pa     = w_tmp[31] ? 32'(-w_tmp) : w_tmp;
                            w_mul_a  = {32'd0, w_pa};
                            w_mul_b  = w_pa;
                            w_mul_go = 1'b1;
                        end
                        4'd1: begin
                            n_sq     = r_acc[43:12];
                            w_mul_a  = {32'd0, w_bb2};
                            w_mul_b  = r_acc[43:12];
                            w_mul_go = 1'b1;
                        end
                        4'd2: begin
                            n_t1     = 32'($signed(w_p32) >>> 11);
                            w_mul_a  = {32'd0, w_ac2};
                            w_mul_b  = r_b6;
                            w_mul_go = 1'b1;
                        end
                        4'd3: begin
                            w_x3     = r_t1 + 32'($signed(w_p32) >>> 11);
                            w_tmp    = ({w_ac1[29:0], 2'b00} + w_x3) << r_oss;
                            n_b3     = 32'($signed(w_tmp + 32'd2) >>> 2);
                            w_mul_a  = {32'd0, w_ac3};
                            w_mul_b  = r_b6;
                            w_mul_go = 1'b1;
                        end
                        4'd4: begin
                            n_t1     = 32'($signed(w_p32) >>> 13);
                            w_mul_a  = {32'd0, w_bb1};
                            w_mul_b  = r_sq;
                            w_mul_go = 1'b1;
                        end
                        4'd5: begin
                            w_tmp    = r_t1 + 32'($signed(w_p32) >>> 16) + 32'd2;
                            w_x3     = 32'($signed(w_tmp) >>> 2);
                            w_mul_a  = {32'd0, w_ac4};
                            w_mul_b  = w_x3 + C_32768;
                            w_mul_go = 1'b1;
                        end
                        4'd6: begin
                            n_b4     = w_p32 >> 15;
                            w_mul_a  = {32'd0, w_up - r_b3};
                            w_mul_b  = C_50000 >> r_oss;
                            w_mul_go = 1'b1;
                        end
                        4'd7: begin
                            n_b7 = w_p32;
                            if (r_b4 == 32'd0) begin
                                n_res = '0; n_err = 1'b1; w_fin = 1'b1;
                            end else begin
                                w_div_n  = (w_p32 < C_HALF) ? {w_p32[30:0], 1'b0} : w_p32;
                                w_div_d  = r_b4;
                                w_div_go = 1'b1;
                            end
                        end
                        4'd8: begin
                            w_tmp    = (r_b7 < C_HALF) ? r_quo : {r_quo[30:0], 1'b0};
                            n_p      = w_tmp;
                            w_pa     = 32'($signed(w_tmp) >>> 8);
                            w_mul_a  = {32'd0, w_pa};
                            w_mul_b  = w_pa;
                            w_mul_go = 1'b1;
                        end
                        4'd9: begin
                            w_mul_a  = {32'd0, w_p32};
                            w_mul_b  = C_3038;
                            w_mul_go = 1'b1;
                        end
                        4'd10: begin
                            n_t1     = 32'($signed(w_p32) >>> 16);
                            w_mul_a  = {32'd0, C_M7357};
                            w_mul_b  = r_p;
                            w_mul_go = 1'b1;
                        end
                        default: begin
                            w_tmp = r_t1 + 32'($signed(w_p32) >>> 16) + C_3791;
                            n_res = r_p + 32'($signed(w_tmp) >>> 4);
                            n_err = 1'b0;
                            w_fin = 1'b1;
                        end
                    endcase
                end
                if (w_mul_go) begin
                    n_ma = w_mul_a; n_mb = w_mul_b; n_acc = '0; n_cnt = '0;
                    n_step = r_step + 4'd1; n_state = S_MUL;
                end
                if (w_div_go) begin
                    n_quo = w_div_n; n_dvs = w_div_d; n_rem = '0; n_cnt = '0;
                    n_step = r_step + 4'd1; n_state = S_DIV;
                end
                if (w_fin) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ov || o_out.ready) begin
                    n_ov    = 1'b1;
                    n_okind = r_kind;
                    n_oval  = r_res;
                    n_oerr  = r_err;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_b5    <= '0;
            r_ov    <= 1'b0;
            r_ac12  <= '0; r_ac34 <= '0; r_ac56 <= '0;
            r_b12   <= '0; r_mcmd <= '0; r_oss  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_b5    <= n_b5;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_AC1_AC2: r_ac12 <= i_cfg_data;
                    CFG_AC3_AC4: r_ac34 <= i_cfg_data;
                    CFG_AC5_AC6: r_ac56 <= i_cfg_data;
                    CFG_B1_B2:   r_b12  <= i_cfg_data;
                    CFG_MC_MD:   r_mcmd <= i_cfg_data;
                    CFG_OSS:     r_oss  <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind; r_raw <= n_raw;
        r_ma <= n_ma; r_mb <= n_mb; r_acc <= n_acc; r_cnt <= n_cnt;
        r_rem <= n_rem; r_quo <= n_quo; r_dvs <= n_dvs; r_neg <= n_neg;
        r_t1 <= n_t1; r_b6 <= n_b6; r_sq <= n_sq; r_b3 <= n_b3;
        r_b4 <= n_b4; r_b7 <= n_b7; r_p <= n_p;
        r_res <= n_res; r_err <= n_err;
        r_okind <= n_okind; r_oval <= n_oval; r_oerr <= n_oerr;
    end

endmodule
`default_nettype wire

>>> design/bcomp_checker.sv
// Port-level checks for barometer_compensation, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module bcomp_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire        i_out_err,
    input wire [31:0] i_out_value
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("ready stayed high after item accepted");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output item dropped while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_err) |-> (i_out_value == 32'd0))
        else $error("divide error with nonzero value");

endmodule

bind barometer_compensation bcomp_checker u_bcomp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_err   (o_out.div_error),
    .i_out_value (o_out.result_value)
);
`default_nettype wire

>>> verif/tb_barometer_compensation.sv
// Testbench for barometer_compensation: temperature and pressure items are
// predicted in a behavioral model and checked field by field at the output.
// Depends on bcomp_pkg, bcomp_in_if, bcomp_out_if and the block itself.
`timescale 1ns / 100ps
module tb_barometer_compensation
    import bcomp_pkg::*;
();

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic        err;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    bcomp_in_if  in_ch ();
    bcomp_out_if out_ch ();

    barometer_compensation uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch.sink),
        .o_out     (out_ch.source),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    logic [31:0] cal_ac12, cal_ac34, cal_ac56, cal_b12, cal_mcmd;
    logic [1:0]  cal_oss;
    logic [31:0] b5_store;
    t_result     pending_results[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          timed_out = 1'b0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.req_type = 1'b0;
        in_ch.raw_reading = '0;
        out_ch.ready = 1'b0;
    end

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] x, input int n);
        return $unsigned($signed(x) >>> n);
    endfunction

    function automatic t_result compensate_temp(input logic [23:0] raw);
        t_result r;
        longint ut, ac5, ac6, mc, md, x1, den, b5, q;
        ut  = raw[15:0];
        ac5 = cal_ac56[31:16];
        ac6 = cal_ac56[15:0];
        mc  = $signed(cal_mcmd[31:16]);
        md  = $signed(cal_mcmd[15:0]);
        x1  = ((ut - ac6) * ac5) >>> 15;
        den = x1 + md;
        r.kind = REQ_TEMP;
        if (den == 0) begin
            r.value = '0;
            r.err = 1'b1;
            return r;
        end
        q = (mc * 2048) / den;
        b5 = x1 + q;
        b5_store = b5[31:0];
        b5 = (b5 + 8) >>> 4;
        r.value = b5[31:0];
        r.err = 1'b0;
        return r;
    endfunction

    function automatic t_result compensate_pres(input logic [23:0] raw);
        t_result r;
        logic [31:0] ac1, ac2, ac3, ac4, b1, b2, up, b6, sq;
        logic [31:0] x1, x2, x3, b3, b4, b7, p;
        longint b6s, sqw;
        ac1 = sext16(cal_ac12[31:16]);
        ac2 = sext16(cal_ac12[15:0]);
        ac3 = sext16(cal_ac34[31:16]);
        ac4 = {16'd0, cal_ac34[15:0]};
        b1  = sext16(cal_b12[31:16]);
        b2  = sext16(cal_b12[15:0]);
        up  = {8'd0, raw} >> (8 - cal_oss);
        b6  = b5_store - 32'd4000;
        b6s = $signed(b6);
        sqw = (b6s * b6s) >>> 12;
        sq  = sqw[31:0];
        x1 = asr(b2 * sq, 11);
        x2 = asr(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = asr(((ac1 * 32'd4 + x3) << cal_oss) + 32'd2, 2);
        x1 = asr(ac3 * b6, 13);
        x2 = asr(b1 * sq, 16);
        x3 = asr(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        b7 = (up - b3) * (32'd50000 >> cal_oss);
        r.kind = REQ_PRES;
        if (b4 == 0) begin
            r.value = '0;
            r.err = 1'b1;
            return r;
        end
        if (b7 < 32'h8000_0000) p = (b7 * 32'd2) / b4;
        else p = (b7 / b4) * 32'd2;
        x1 = asr(p, 8);
        x1 = x1 * x1;
        x1 = asr(x1 * 32'd3038, 16);
        x2 = asr((32'd0 - 32'd7357) * p, 16);
        p = p + asr(x1 + x2 + 32'd3791, 4);
        r.value = p;
        r.err = 1'b0;
        return r;
    endfunction

    task automatic send_item(input logic kind, input logic [23:0] raw);
        t_result r;
        int gap;
        gap = $urandom_range(0, 5);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.req_type <= kind;
        in_ch.raw_reading <= raw;
        do @(posedge i_clk); while (!in_ch.ready);
        r = (kind == REQ_PRES) ? compensate_pres(raw) : compensate_temp(raw);
        pending_results.push_back(r);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_AC1_AC2: cal_ac12 = data;
            CFG_AC3_AC4: cal_ac34 = data;
            CFG_AC5_AC6: cal_ac56 = data;
            CFG_B1_B2:   cal_b12 = data;
            CFG_MC_MD:   cal_mcmd = data;
            default:     cal_oss = data[1:0];
        endcase
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic load_cal(input logic [31:0] a, b, c, d, e, input logic [1:0] oss);
        drain();
        write_reg(CFG_AC1_AC2, a);
        write_reg(CFG_AC3_AC4, b);
        write_reg(CFG_AC5_AC6, c);
        write_reg(CFG_B1_B2, d);
        write_reg(CFG_MC_MD, e);
        write_reg(CFG_OSS, {30'd0, oss});
        i_cfg_we <= 1'b0;
    endtask

    // typical datasheet-like calibration
    task automatic load_typical(input logic [1:0] oss);
        load_cal({16'd408, 16'hFFB8}, {16'hC6D1, 16'd32741}, {16'd32757, 16'd23153},
                 {16'd6190, 16'd4}, {16'hD4BD, 16'd2868}, oss);
    endtask

    task automatic test_reset_state();
        send_item(REQ_PRES, 24'h000000);
        send_item(REQ_TEMP, 24'hFFFFFF);
    endtask

    task automatic test_directed();
        load_typical(2'd0);
        send_item(REQ_TEMP, 24'd27898);
        send_item(REQ_PRES, 24'd23843 << 8);
        send_item(REQ_TEMP, 24'h000000);
        send_item(REQ_PRES, 24'hFFFFFF);
        send_item(REQ_TEMP, 24'h00FFFF);
        send_item(REQ_PRES, 24'h000000);
        load_typical(2'd3);
        send_item(REQ_TEMP, 24'hAB6CFA);
        send_item(REQ_PRES, 24'hFFFFFF);
        send_item(REQ_PRES, 24'h5A5A5A);
        // temperature divisor zero: AC5 = 0, MD = 0
        load_cal(32'd0, 32'h0000_0001, 32'h0000_1234, 32'd0, 32'h7FFF_0000, 2'd1);
        send_item(REQ_TEMP, 24'h001234);
        // pressure with AC4 = 1, AC3 = 0, B1 = B2 = 0: divisor B4 is 1
        send_item(REQ_PRES, 24'h123456);
        // extremes of every calibration field
        load_cal(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'h8000_7FFF, 2'd2);
        send_item(REQ_TEMP, 24'h000000);
        send_item(REQ_PRES, 24'hFFFFFF);
        load_cal(32'h8000_7FFF, 32'h7FFF_0001, 32'h0001_FFFF, 32'h8000_8000,
                 32'h7FFF_8000, 2'd1);
        send_item(REQ_TEMP, 24'hFFFFFF);
        send_item(REQ_PRES, 24'h800000);
    endtask

    task automatic test_random();
        for (int i = 0; i < 1730; i++) begin
            if (i % 150 == 0) begin
                if ($urandom_range(0, 1))
                    load_typical(2'($urandom_range(0, 3)));
                else
                    load_cal($urandom, $urandom, $urandom, $urandom, $urandom,
                             2'($urandom_range(0, 3)));
            end
            if ($urandom_range(0, 2) == 0)
                send_item(REQ_TEMP, 24'($urandom_range(20000, 36000) | ($urandom << 16)));
            else if ($urandom_range(0, 3) == 0)
                send_item(1'($urandom), 24'($urandom));
            else
                send_item(REQ_PRES, 24'($urandom_range(15000, 45000)) << 8 | 24'($urandom & 8'hFF));
        end
    endtask

    initial begin
        cal_ac12 = '0; cal_ac34 = '0; cal_ac56 = '0;
        cal_b12 = '0; cal_mcmd = '0; cal_oss = '0;
        b5_store = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_directed();
        test_random();
        drain();
        if (mismatches == 0 && !timed_out)
            $display("[barometer_compensation] OK");
        else
            $display("[barometer_compensation] ERROR");
        $finish;
    end

    // receiver stalls
    always @(posedge i_clk) begin
        int wait_left;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            wait_left = 0;
        end else if (out_ch.valid && out_ch.ready) begin
            wait_left = $urandom_range(0, 5);
            out_ch.ready <= (wait_left == 0);
        end else if (wait_left > 0) begin
            wait_left--;
            out_ch.ready <= (wait_left == 0);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item");
            end else begin
                want = pending_results.pop_front();
                if (want.kind !== out_ch.result_kind || want.value !== out_ch.result_value
                        || want.err !== out_ch.div_error) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp kind %0d val %0d err %0d, got %0d %0d %0d",
                                 want.kind, $signed(want.value), want.err,
                                 out_ch.result_kind, out_ch.result_value, out_ch.div_error);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            timed_out = 1'b1;
            $display("[barometer_compensation] ERROR");
            $finish;
        end
    end
endmodule

>>> barometer_compensation.f
design/bcomp_pkg.sv
design/bcomp_in_if.sv
design/bcomp_out_if.sv
design/barometer_compensation.sv
design/bcomp_checker.sv
verif/tb_barometer_compensation.sv
